### rtl/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared constants and types of the bar-graph delta renderer.
// ----------------------------------------------------------------------------
package bdr_pkg;

  // Bar geometry in display columns
  localparam int BAR_WIDTH  = 200;
  localparam int BAR_LEFT   = 28;
  localparam int BAR_MIDDLE = 128;
  localparam int BAR_HALF   = BAR_WIDTH / 2;

  // Shown bar length, two's complement
  localparam int LEN_W   = 9;
  // Signed width for column arithmetic
  localparam int ARITH_W = 11;

  // Divide by 5: q = (r * 52429) >> 18, exact for 0 <= r < 65536
  localparam int DIV5_MUL   = 52429;
  localparam int DIV5_SHIFT = 18;
  localparam int QUOT_W     = 13;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef logic signed [LEN_W-1:0]   len_t;
  typedef logic signed [ARITH_W-1:0] coord_t;

  localparam coord_t LEFT_C   = coord_t'(BAR_LEFT);
  localparam coord_t MIDDLE_C = coord_t'(BAR_MIDDLE);
  localparam coord_t WIDTH_C  = coord_t'(BAR_WIDTH);

  localparam logic PAINT_CLEAR = 1'b0;
  localparam logic PAINT_FILL  = 1'b1;

  localparam logic STYLE_POS = 1'b0;
  localparam logic STYLE_CEN = 1'b1;

  // One rectangle command
  typedef struct packed {
    logic       paint;
    logic [7:0] x_start;
    logic [7:0] span;
  } cmd_t;

  // All commands caused by one item, slot 0 first
  typedef struct packed {
    logic [1:0]      cnt;
    cmd_t [2:0]      cmds;
  } plan_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/bdr_front.sv
// ----------------------------------------------------------------------------
// bdr_front
// Accepts items, scales the reading, and turns it into a command plan
// against the bar state it keeps.
// ----------------------------------------------------------------------------
module bdr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic                              cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tuser,
  input  logic [bdr_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  bdr_pkg::q_stat_t                  q_stat,
  output logic                              q_push,
  output bdr_pkg::plan_t                    q_plan
);

  function automatic bdr_pkg::cmd_t mk_cmd(input logic p, input bdr_pkg::coord_t x,
                                           input bdr_pkg::coord_t s);
    bdr_pkg::cmd_t c;
    c.paint   = p;
    c.x_start = x[7:0];
    c.span    = s[7:0];
    return c;
  endfunction

  // bar state
  logic             bar_enable;
  bdr_pkg::len_t    shown_length;
  logic             shown_style;
  logic             bar_present;

  // stage A: scaled reading
  logic             a_valid;
  logic             a_style;
  bdr_pkg::len_t    a_v;

  // scaling
  logic signed [15:0]              rd;
  logic [30:0]                     prod;
  logic [bdr_pkg::QUOT_W-1:0]      quot;
  bdr_pkg::len_t                   v_pos;
  bdr_pkg::len_t                   v_cen;

  // planning
  logic              chg;
  logic              pres_e;
  bdr_pkg::coord_t   cur;
  bdr_pkg::coord_t   v;
  logic              d0_p, d1_p;
  bdr_pkg::coord_t   d0_x, d0_s, d1_x, d1_s;
  logic              d0v, d1v;
  logic              b_adv;

  assign rd   = s_tdata;
  assign prod = 31'(rd[14:0]) * 31'(bdr_pkg::DIV5_MUL);
  assign quot = prod[bdr_pkg::DIV5_SHIFT +: bdr_pkg::QUOT_W];

  always_comb begin
    if (rd[15]) begin
      v_pos = '0;
    end else if (quot > bdr_pkg::QUOT_W'(bdr_pkg::BAR_WIDTH - 1)) begin
      v_pos = bdr_pkg::len_t'(bdr_pkg::BAR_WIDTH - 1);
    end else begin
      v_pos = bdr_pkg::len_t'(quot);
    end
    if (rd > 16'(bdr_pkg::BAR_HALF)) begin
      v_cen = bdr_pkg::len_t'(bdr_pkg::BAR_HALF);
    end else if (rd < -16'sd1 * 16'(bdr_pkg::BAR_HALF)) begin
      v_cen = -bdr_pkg::len_t'(bdr_pkg::BAR_HALF);
    end else begin
      v_cen = rd[bdr_pkg::LEN_W-1:0];
    end
  end

  // A style change clears the area and leaves bar zero drawn
  assign chg    = a_style != shown_style;
  assign pres_e = chg | bar_present;
  assign cur    = chg ? '0 : bdr_pkg::coord_t'(shown_length);
  assign v      = bdr_pkg::coord_t'(a_v);

  always_comb begin
    d0_p = bdr_pkg::PAINT_CLEAR;
    d0_x = '0;
    d0_s = '0;
    d1_p = bdr_pkg::PAINT_CLEAR;
    d1_x = '0;
    d1_s = '0;
    if (a_style == bdr_pkg::STYLE_POS) begin
      if (!pres_e) begin
        d0_p = bdr_pkg::PAINT_FILL;
        d0_x = bdr_pkg::LEFT_C;
        d0_s = v + 2'sd1;
      end else if (cur < v) begin
        d0_p = bdr_pkg::PAINT_FILL;
        d0_x = bdr_pkg::LEFT_C + cur + 2'sd1;
        d0_s = v - cur;
      end else begin
        d0_x = bdr_pkg::LEFT_C + v + 2'sd1;
        d0_s = cur - v;
      end
    end else begin
      if (!pres_e) begin
        d0_p = bdr_pkg::PAINT_FILL;
        if (v >= 0) begin
          d0_x = bdr_pkg::MIDDLE_C;
          d0_s = v + 2'sd1;
        end else begin
          d0_x = bdr_pkg::MIDDLE_C + v;
          d0_s = 2'sd1 - v;
        end
      end else if ((v < 0 && cur > 0) || (v > 0 && cur < 0)) begin
        // sign flip: clear old side, fill new side
        d1_p = bdr_pkg::PAINT_FILL;
        if (cur > 0) begin
          d0_x = bdr_pkg::MIDDLE_C + 2'sd1;
          d0_s = cur;
          d1_x = bdr_pkg::MIDDLE_C + v;
          d1_s = -v;
        end else begin
          d0_x = bdr_pkg::MIDDLE_C + cur;
          d0_s = -cur;
          d1_x = bdr_pkg::MIDDLE_C + 2'sd1;
          d1_s = v;
        end
      end else if (v > 0 || cur > 0) begin
        if (cur < v) begin
          d0_p = bdr_pkg::PAINT_FILL;
          d0_x = bdr_pkg::MIDDLE_C + cur + 2'sd1;
          d0_s = v - cur;
        end else begin
          d0_x = bdr_pkg::MIDDLE_C + v + 2'sd1;
          d0_s = cur - v;
        end
      end else if (v < 0 || cur < 0) begin
        if (cur > v) begin
          d0_p = bdr_pkg::PAINT_FILL;
          d0_x = bdr_pkg::MIDDLE_C + v;
          d0_s = cur - v;
        end else begin
          d0_x = bdr_pkg::MIDDLE_C + cur;
          d0_s = v - cur;
        end
      end
    end
  end

  // zero-width commands are dropped
  assign d0v = d0_s > 0;
  assign d1v = d1_s > 0;

  always_comb begin
    q_plan.cmds = '0;
    q_plan.cnt  = '0;
    if (chg) begin
      q_plan.cmds[0] = mk_cmd(bdr_pkg::PAINT_CLEAR, bdr_pkg::LEFT_C, bdr_pkg::WIDTH_C);
      q_plan.cmds[1] = mk_cmd(bdr_pkg::PAINT_FILL,
                              (a_style == bdr_pkg::STYLE_CEN) ? bdr_pkg::MIDDLE_C
                                                              : bdr_pkg::LEFT_C,
                              bdr_pkg::coord_t'(1));
      q_plan.cmds[2] = mk_cmd(d0_p, d0_x, d0_s);
      q_plan.cnt     = 2'd2 + {1'b0, d0v};
    end else if (d0v) begin
      q_plan.cmds[0] = mk_cmd(d0_p, d0_x, d0_s);
      q_plan.cmds[1] = mk_cmd(d1_p, d1_x, d1_s);
      q_plan.cnt     = 2'd1 + {1'b0, d1v};
    end else begin
      q_plan.cmds[0] = mk_cmd(d1_p, d1_x, d1_s);
      q_plan.cnt     = {1'b0, d1v};
    end
  end

  // an item leaves stage A once its plan has a queue slot or needs none
  assign b_adv    = a_valid && (!bar_enable || q_plan.cnt == '0 || !q_stat.full);
  assign q_push   = a_valid && bar_enable && q_plan.cnt != '0 && !q_stat.full;
  assign s_tready = !a_valid || b_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_enable   <= 1'b0;
      shown_length <= '0;
      shown_style  <= bdr_pkg::STYLE_CEN;
      bar_present  <= 1'b0;
      a_valid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        bar_enable   <= cfg_wdata;
        shown_length <= '0;
        shown_style  <= bdr_pkg::STYLE_CEN;
        bar_present  <= 1'b0;
      end else if (b_adv && bar_enable) begin
        shown_length <= a_v;
        shown_style  <= a_style;
        bar_present  <= 1'b1;
      end
      if (s_tready) begin
        a_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_style <= s_tuser;
      a_v     <= (s_tuser == bdr_pkg::STYLE_CEN) ? v_cen : v_pos;
    end
  end

endmodule

### rtl/bdr_plan_q.sv
// ----------------------------------------------------------------------------
// bdr_plan_q
// Two-entry queue of command plans between front and back.
// ----------------------------------------------------------------------------
module bdr_plan_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bdr_pkg::plan_t   wr_plan,
  input  logic             pop,
  output bdr_pkg::plan_t   rd_plan,
  output bdr_pkg::q_stat_t stat
);

  bdr_pkg::plan_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign rd_plan    = slots[rd_ptr];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_plan;
    end
  end

endmodule

### rtl/bdr_back.sv
// ----------------------------------------------------------------------------
// bdr_back
// Steps a plan into the output register, one command per cycle while free.
// ----------------------------------------------------------------------------
module bdr_back (
  input  logic                              clk,
  input  logic                              rst,
  input  bdr_pkg::plan_t                    head,
  input  bdr_pkg::q_stat_t                  q_stat,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bdr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  bdr_pkg::plan_t cur;
  logic [1:0]     idx;
  logic           busy;
  logic           out_free;
  logic           issue;
  logic           last_cmd;
  bdr_pkg::cmd_t  cmd;

  assign out_free = !m_tvalid || m_tready;
  assign issue    = busy && out_free;
  assign last_cmd = idx == cur.cnt - 2'd1;
  assign pop      = !q_stat.empty && (!busy || (issue && last_cmd));

  always_comb begin
    case (idx)
      2'd0:    cmd = cur.cmds[0];
      2'd1:    cmd = cur.cmds[1];
      default: cmd = cur.cmds[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // a new plan restarts the index, else each issue steps it
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (issue) begin
        idx <= idx + 2'd1;
        if (last_cmd) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (issue) begin
      m_tdata <= {7'b0, cmd.span, cmd.x_start, cmd.paint};
      m_tlast <= last_cmd;
    end
  end

endmodule

### rtl/bargraph_delta_renderer.sv
// ----------------------------------------------------------------------------
// bargraph_delta_renderer
// Turns readings into fill/clear rectangle commands that update a bar graph.
// ----------------------------------------------------------------------------
// Input stream: s_tuser = style (0 positive, 1 centred), s_tdata = signed
//   16-bit reading. Output stream: one rectangle command per item, tlast on
//   the final command caused by a reading. A reading gives 0 to 3 commands.
// Config: bar_enable is written with cfg_wen/cfg_wdata, by the user only while idle
//   (the block does not enforce it); any write also wipes the bar state (length 0, centred, nothing drawn).
// Path: a reading is registered in the scale stage, its plan goes into the queue,
//   the back sequencer loads it, and each command is registered for output.
// Throughput: the back sequencer issues one command per cycle while the output
//   register is free, a reading's commands in turn; readings that cause no
//   command pass at one per cycle.
// Reset: rst clears the bar state, disables drawing and empties the queue.
// Stall: while m_tready is low the output register holds its command; the
//   two-entry plan queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module bargraph_delta_renderer (
  input  logic        clk,
  input  logic        rst,
  // configuration: bar_enable
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  // readings
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // [0] style
  input  logic [15:0] s_tdata,   // [15:0] reading
  // rectangle commands
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] paint, [8:1] x_start, [16:9] span, rest zero
  output logic        m_tlast
);

  // front -> queue
  logic             q_push;
  bdr_pkg::plan_t   q_wr_plan;
  // queue -> back
  logic             q_pop;
  bdr_pkg::plan_t   q_rd_plan;
  bdr_pkg::q_stat_t q_stat;

  // scaling, state tracking, command planning
  bdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_plan    (q_wr_plan)
  );

  // plans wait here so either side can stall on its own
  bdr_plan_q u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_plan (q_wr_plan),
    .pop     (q_pop),
    .rd_plan (q_rd_plan),
    .stat    (q_stat)
  );

  // one command per cycle into the output register, while it is free
  bdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_rd_plan),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // zero-width commands must never leave the block
  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:9] != 8'd0)
    else $error("zero-width command issued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("plan pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("plan popped from empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && q_stat.empty)
    else $error("output or queue busy after reset");

endmodule
